// ----- rtl/ggw_pkg.sv -----
package ggw_pkg;

	localparam int CH_BITS     = 8;
	localparam int LIMIT_BITS  = 12;
	localparam int START_BITS  = 16;
	localparam int LENGTH_BITS = 12;
	localparam int LINE_BITS   = 16;
	localparam int COLUMN_BITS = 12;

	localparam int QDEPTH    = 8;
	localparam int QPTR_BITS = 3;
	localparam int QCNT_BITS = 4;

	localparam logic [CH_BITS-1:0] CH_LF    = 8'h0A;
	localparam logic [CH_BITS-1:0] CH_CR    = 8'h0D;
	localparam logic [CH_BITS-1:0] CH_SP    = 8'h20;
	localparam logic [CH_BITS-1:0] CH_WS_LO = 8'h09;
	localparam logic [CH_BITS-1:0] CH_WS_HI = 8'h0D;

	localparam logic CFG_WRAP_ENABLE = 1'b0;
	localparam logic CFG_LINE_LIMIT  = 1'b1;

	localparam logic                  WRAP_ENABLE_RESET = 1'b1;
	localparam logic [LIMIT_BITS-1:0] LINE_LIMIT_RESET  = 12'd80;

	typedef enum logic [1:0] {
		KIND_WORD,
		KIND_EMPTY,
		KIND_RAW,
		KIND_END
	} kind_t;

	typedef struct packed {
		logic [CH_BITS-1:0] ch;
		logic               last_char;
	} text_t;

	typedef struct packed {
		kind_t                  kind;
		logic [START_BITS-1:0]  start_res;
		logic [LENGTH_BITS-1:0] length;
		logic [LINE_BITS-1:0]   line_number;
		logic [COLUMN_BITS-1:0] column;
		logic                   overflow;
		logic                   last;
	} rec_t;

endpackage

// ----- rtl/ggw_stream_if.sv -----
interface ggw_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/ggw_step.sv -----
module ggw_step #(
	parameter int POS_BITS = 16,
	parameter int LEN_BITS = 12
) (
	input  logic                                wrap_enable,
	input  logic [ggw_pkg::LIMIT_BITS-1:0]      line_limit,
	input  ggw_pkg::text_t                      item,
	input  logic [POS_BITS-1:0]                 position,
	input  logic [POS_BITS-1:0]                 word_start,
	input  logic [LEN_BITS-1:0]                 word_length,
	input  logic                                word_sat,
	input  logic [LEN_BITS-1:0]                 line_chars,
	input  logic [POS_BITS-1:0]                 line_index,
	input  logic                                in_word,
	input  logic                                para_has_chars,
	input  logic                                para_all_blank,
	input  logic [POS_BITS-1:0]                 raw_start,
	input  logic [LEN_BITS-1:0]                 raw_length,
	input  logic                                raw_sat,
	output logic [POS_BITS-1:0]                 position_nx,
	output logic [POS_BITS-1:0]                 word_start_nx,
	output logic [LEN_BITS-1:0]                 word_length_nx,
	output logic                                word_sat_nx,
	output logic [LEN_BITS-1:0]                 line_chars_nx,
	output logic [POS_BITS-1:0]                 line_index_nx,
	output logic                                in_word_nx,
	output logic                                para_has_chars_nx,
	output logic                                para_all_blank_nx,
	output logic [POS_BITS-1:0]                 raw_start_nx,
	output logic [LEN_BITS-1:0]                 raw_length_nx,
	output logic                                raw_sat_nx,
	output logic [1:0]                          rec_cnt,
	output ggw_pkg::rec_t                       rec0,
	output ggw_pkg::rec_t                       rec1
);

	localparam logic [LEN_BITS-1:0] LMAX = '1;
	localparam int CW = ((LEN_BITS > ggw_pkg::LIMIT_BITS) ? LEN_BITS : ggw_pkg::LIMIT_BITS) + 2;

	function automatic ggw_pkg::rec_t mk_rec(
		input ggw_pkg::kind_t      kind,
		input logic [POS_BITS-1:0] start,
		input logic [LEN_BITS-1:0] len,
		input logic [POS_BITS-1:0] line,
		input logic [LEN_BITS-1:0] col,
		input logic                ovf
	);
		ggw_pkg::rec_t r;
		r.kind        = kind;
		r.start_res   = ggw_pkg::START_BITS'(32'(start));
		r.length      = ggw_pkg::LENGTH_BITS'(16'(len));
		r.line_number = ggw_pkg::LINE_BITS'(32'(line));
		r.column      = ggw_pkg::COLUMN_BITS'(16'(col));
		r.overflow    = ovf;
		r.last        = 1'b0;
		return r;
	endfunction

	always_comb begin
		logic                ws;
		logic                is_lf;
		logic                place;
		logic                brk;
		logic [CW-1:0]       sum;
		logic [LEN_BITS:0]   colw;
		logic [LEN_BITS:0]   endw;
		logic [LEN_BITS-1:0] col;
		logic                ovf;
		logic [1:0]          n;
		ggw_pkg::rec_t       r;

		position_nx       = position;
		word_start_nx     = word_start;
		word_length_nx    = word_length;
		word_sat_nx       = word_sat;
		line_chars_nx     = line_chars;
		line_index_nx     = line_index;
		in_word_nx        = in_word;
		para_has_chars_nx = para_has_chars;
		para_all_blank_nx = para_all_blank;
		raw_start_nx      = raw_start;
		raw_length_nx     = raw_length;
		raw_sat_nx        = raw_sat;
		rec0              = '0;
		rec1              = '0;
		n                 = 2'd0;
		place             = 1'b0;
		brk               = 1'b0;
		sum               = '0;
		colw              = '0;
		endw              = '0;
		col               = '0;
		ovf               = 1'b0;
		r                 = '0;

		is_lf = item.ch == ggw_pkg::CH_LF;
		ws    = item.ch == ggw_pkg::CH_SP ||
			(item.ch >= ggw_pkg::CH_WS_LO && item.ch <= ggw_pkg::CH_WS_HI);

		if (wrap_enable) begin
			if (!ws) begin
				if (!in_word) begin
					word_start_nx  = position;
					word_length_nx = LEN_BITS'(1);
					word_sat_nx    = 1'b0;
				end else if (word_length == LMAX) begin
					word_sat_nx = 1'b1;
				end else begin
					word_length_nx = word_length + LEN_BITS'(1);
				end
				in_word_nx        = 1'b1;
				para_all_blank_nx = 1'b0;
			end
			place = ws ? in_word : item.last_char;
			if (place) begin
				ovf  = word_sat_nx;
				sum  = CW'(line_chars) + CW'(1) + CW'(word_length_nx);
				brk  = para_has_chars && (sum > CW'(line_limit));
				if (brk) begin
					line_index_nx = line_index + POS_BITS'(1);
				end
				colw = (!brk && para_has_chars) ? ((LEN_BITS+1)'(line_chars) + (LEN_BITS+1)'(1))
					: '0;
				if (colw > {1'b0, LMAX}) begin
					col = LMAX;
					ovf = 1'b1;
				end else begin
					col = colw[LEN_BITS-1:0];
				end
				endw = {1'b0, col} + {1'b0, word_length_nx};
				line_chars_nx     = (endw > {1'b0, LMAX}) ? LMAX : endw[LEN_BITS-1:0];
				para_has_chars_nx = 1'b1;
				in_word_nx        = 1'b0;
				rec0 = mk_rec(ggw_pkg::KIND_WORD, word_start_nx, word_length_nx, line_index_nx,
					col, ovf);
				n = 2'd1;
			end
			if (ws && item.ch != ggw_pkg::CH_SP && item.ch != ggw_pkg::CH_CR && !is_lf) begin
				para_all_blank_nx = 1'b0;
			end
			if (is_lf || item.last_char) begin
				if (para_all_blank_nx) begin
					r = mk_rec(ggw_pkg::KIND_EMPTY, '0, '0, line_index_nx, '0, 1'b0);
					if (n == 2'd0) begin
						rec0 = r;
					end else begin
						rec1 = r;
					end
					n = n + 2'd1;
					line_index_nx = line_index_nx + POS_BITS'(1);
				end else if (para_has_chars_nx) begin
					line_index_nx = line_index_nx + POS_BITS'(1);
				end
				line_chars_nx     = '0;
				para_has_chars_nx = 1'b0;
				para_all_blank_nx = 1'b1;
			end
		end else begin
			if (is_lf) begin
				rec0 = mk_rec(ggw_pkg::KIND_RAW, raw_start, raw_length, line_index, '0, raw_sat);
				n = 2'd1;
				line_index_nx = line_index + POS_BITS'(1);
				raw_start_nx  = position + POS_BITS'(1);
				raw_length_nx = '0;
				raw_sat_nx    = 1'b0;
				if (item.last_char) begin
					rec1 = mk_rec(ggw_pkg::KIND_RAW, raw_start_nx, '0, line_index_nx, '0, 1'b0);
					n = 2'd2;
					line_index_nx = line_index_nx + POS_BITS'(1);
				end
			end else begin
				if (item.ch != ggw_pkg::CH_CR) begin
					if (raw_length == LMAX) begin
						raw_sat_nx = 1'b1;
					end else begin
						raw_length_nx = raw_length + LEN_BITS'(1);
					end
				end
				if (item.last_char && raw_length_nx != '0) begin
					rec0 = mk_rec(ggw_pkg::KIND_RAW, raw_start, raw_length_nx, line_index, '0,
						raw_sat_nx);
					n = 2'd1;
					line_index_nx = line_index + POS_BITS'(1);
				end
			end
		end

		position_nx = position + POS_BITS'(1);

		if (item.last_char) begin
			if (n == 2'd0) begin
				rec0 = mk_rec(ggw_pkg::KIND_END, '0, '0, line_index_nx, '0, 1'b0);
				n = 2'd1;
			end
			if (n == 2'd1) begin
				rec0.last = 1'b1;
			end else begin
				rec1.last = 1'b1;
			end
			position_nx       = '0;
			word_start_nx     = '0;
			word_length_nx    = '0;
			word_sat_nx       = 1'b0;
			line_chars_nx     = '0;
			line_index_nx     = '0;
			in_word_nx        = 1'b0;
			para_has_chars_nx = 1'b0;
			para_all_blank_nx = 1'b1;
			raw_start_nx      = '0;
			raw_length_nx     = '0;
			raw_sat_nx        = 1'b0;
		end

		rec_cnt = n;
	end

endmodule

// ----- rtl/ggw_queue.sv -----
module ggw_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      push_cnt,
	input  ggw_pkg::rec_t                   push0,
	input  ggw_pkg::rec_t                   push1,
	output logic [ggw_pkg::QCNT_BITS-1:0]   count,
	ggw_stream_if.source                    out
);

	ggw_pkg::rec_t                   mem_q [ggw_pkg::QDEPTH];
	logic [ggw_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [ggw_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [ggw_pkg::QCNT_BITS-1:0]   count_q;
	logic                            pop;

	assign pop         = out.valid && out.ready;
	assign out.valid   = count_q != '0;
	assign out.payload = mem_q[rd_ptr_q];
	assign count       = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ggw_pkg::QPTR_BITS'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ggw_pkg::QPTR_BITS'(1);
			end
			count_q <= count_q + ggw_pkg::QCNT_BITS'(push_cnt)
				- ggw_pkg::QCNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_q + ggw_pkg::QPTR_BITS'(1)] <= push1;
		end
	end

endmodule

// ----- rtl/greedy_word_wrap_top.sv -----
// Greedy fixed-pitch word wrap. One text byte is taken per cycle while input ready is
// high; each byte is registered, classified and folded into the wrap counters in the
// next cycle, and the placement records it causes (none, one or two) land in an
// 8-entry output queue, so a byte's first record passes the input register and the
// queue before it can transfer.
// Input ready stays high as long as the queue has room for the worst case of the
// byte in flight plus a new one; a sink that takes one record per cycle keeps the
// rate at one byte per cycle, except that bytes producing two records fill the queue
// and can hold input ready low. Configuration writes take effect on the next cycle.
module greedy_word_wrap_top #(
	parameter int POS_BITS = 16,
	parameter int LEN_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [ggw_pkg::LIMIT_BITS-1:0]    cfg_data,
	ggw_stream_if.sink                        text,
	ggw_stream_if.source                      placement
);

	logic                           wrap_enable_q;
	logic [ggw_pkg::LIMIT_BITS-1:0] line_limit_q;

	logic           valid_s1;
	ggw_pkg::text_t item_s1;

	logic [POS_BITS-1:0] position_q,     position_nx;
	logic [POS_BITS-1:0] word_start_q,   word_start_nx;
	logic [LEN_BITS-1:0] word_length_q,  word_length_nx;
	logic                word_sat_q,     word_sat_nx;
	logic [LEN_BITS-1:0] line_chars_q,   line_chars_nx;
	logic [POS_BITS-1:0] line_index_q,   line_index_nx;
	logic                in_word_q,      in_word_nx;
	logic                para_has_q,     para_has_nx;
	logic                para_blank_q,   para_blank_nx;
	logic [POS_BITS-1:0] raw_start_q,    raw_start_nx;
	logic [LEN_BITS-1:0] raw_length_q,   raw_length_nx;
	logic                raw_sat_q,      raw_sat_nx;

	logic [1:0]                    rec_cnt;
	logic [1:0]                    push_cnt;
	ggw_pkg::rec_t                 rec0;
	ggw_pkg::rec_t                 rec1;
	logic [ggw_pkg::QCNT_BITS-1:0] q_count;
	logic                          take;

	assign text.ready = (5'(q_count) + (valid_s1 ? 5'd2 : 5'd0) + 5'd2)
		<= 5'(ggw_pkg::QDEPTH);
	assign take     = text.valid && text.ready;
	assign push_cnt = valid_s1 ? rec_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_enable_q <= ggw_pkg::WRAP_ENABLE_RESET;
			line_limit_q  <= ggw_pkg::LINE_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ggw_pkg::CFG_WRAP_ENABLE: wrap_enable_q <= cfg_data[0];
				ggw_pkg::CFG_LINE_LIMIT:  line_limit_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= text.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= '0;
			word_start_q  <= '0;
			word_length_q <= '0;
			word_sat_q    <= 1'b0;
			line_chars_q  <= '0;
			line_index_q  <= '0;
			in_word_q     <= 1'b0;
			para_has_q    <= 1'b0;
			para_blank_q  <= 1'b1;
			raw_start_q   <= '0;
			raw_length_q  <= '0;
			raw_sat_q     <= 1'b0;
		end else if (valid_s1) begin
			position_q    <= position_nx;
			word_start_q  <= word_start_nx;
			word_length_q <= word_length_nx;
			word_sat_q    <= word_sat_nx;
			line_chars_q  <= line_chars_nx;
			line_index_q  <= line_index_nx;
			in_word_q     <= in_word_nx;
			para_has_q    <= para_has_nx;
			para_blank_q  <= para_blank_nx;
			raw_start_q   <= raw_start_nx;
			raw_length_q  <= raw_length_nx;
			raw_sat_q     <= raw_sat_nx;
		end
	end

	ggw_step #(
		.POS_BITS (POS_BITS),
		.LEN_BITS (LEN_BITS)
	) u_step (
		.wrap_enable       (wrap_enable_q),
		.line_limit        (line_limit_q),
		.item              (item_s1),
		.position          (position_q),
		.word_start        (word_start_q),
		.word_length       (word_length_q),
		.word_sat          (word_sat_q),
		.line_chars        (line_chars_q),
		.line_index        (line_index_q),
		.in_word           (in_word_q),
		.para_has_chars    (para_has_q),
		.para_all_blank    (para_blank_q),
		.raw_start         (raw_start_q),
		.raw_length        (raw_length_q),
		.raw_sat           (raw_sat_q),
		.position_nx       (position_nx),
		.word_start_nx     (word_start_nx),
		.word_length_nx    (word_length_nx),
		.word_sat_nx       (word_sat_nx),
		.line_chars_nx     (line_chars_nx),
		.line_index_nx     (line_index_nx),
		.in_word_nx        (in_word_nx),
		.para_has_chars_nx (para_has_nx),
		.para_all_blank_nx (para_blank_nx),
		.raw_start_nx      (raw_start_nx),
		.raw_length_nx     (raw_length_nx),
		.raw_sat_nx        (raw_sat_nx),
		.rec_cnt           (rec_cnt),
		.rec0              (rec0),
		.rec1              (rec1)
	);

	ggw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push0    (rec0),
		.push1    (rec1),
		.count    (q_count),
		.out      (placement)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ggw_pkg::QCNT_BITS'(ggw_pkg::QDEPTH))
		else $error("output queue overrun");

	a_last_byte_records: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.last_char |-> rec_cnt != 2'd0 &&
		((rec_cnt == 2'd1 && rec0.last) || (rec_cnt == 2'd2 && rec1.last && !rec0.last)))
		else $error("final byte without a closing record");

	a_text_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.last_char |=> position_q == '0 && line_index_q == '0 &&
		para_blank_q && !in_word_q)
		else $error("state not cleared after final byte");

	a_record_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> rec_cnt != 2'd3)
		else $error("more than two records for one byte");

endmodule

// ----- bench/tb_top.sv -----
module tb_top;

	localparam int SAT = (1 << ggw_pkg::LENGTH_BITS) - 1;

	class wrap_checker;
		ggw_pkg::rec_t pending_recs[$];
		ggw_pkg::rec_t byte_recs[$];
		int mismatches;
		int rec_no;
		bit wrap_on;
		bit [ggw_pkg::LIMIT_BITS-1:0] limit;
		bit [ggw_pkg::START_BITS-1:0] pos, word_start, raw_start;
		bit [ggw_pkg::LINE_BITS-1:0] line_idx;
		bit [ggw_pkg::LENGTH_BITS-1:0] word_len, line_chars, raw_len;
		bit in_word, para_chars, para_blank, word_sat, raw_sat;

		function new();
			mismatches = 0;
			rec_no = 0;
			wrap_on = ggw_pkg::WRAP_ENABLE_RESET;
			limit = ggw_pkg::LINE_LIMIT_RESET;
			clear_text();
		endfunction

		function void clear_text();
			pos = '0;
			word_start = '0;
			raw_start = '0;
			line_idx = '0;
			word_len = '0;
			line_chars = '0;
			raw_len = '0;
			in_word = 1'b0;
			para_chars = 1'b0;
			para_blank = 1'b1;
			word_sat = 1'b0;
			raw_sat = 1'b0;
		endfunction

		function void emit(ggw_pkg::kind_t k, bit [ggw_pkg::START_BITS-1:0] s,
				bit [ggw_pkg::LENGTH_BITS-1:0] n, bit [ggw_pkg::COLUMN_BITS-1:0] col,
				bit ovf);
			ggw_pkg::rec_t r;
			r.kind = k;
			r.start_res = s;
			r.length = n;
			r.line_number = line_idx;
			r.column = col;
			r.overflow = ovf;
			r.last = 1'b0;
			byte_recs = {byte_recs, r};
		endfunction

		function void place_word();
			int col;
			int span;
			bit ovf;
			ovf = word_sat;
			if (para_chars && int'(line_chars) + 1 + int'(word_len) > int'(limit)) begin
				line_idx++;
				col = 0;
			end else begin
				col = para_chars ? int'(line_chars) + 1 : 0;
			end
			if (col > SAT) begin
				col = SAT;
				ovf = 1'b1;
			end
			span = col + int'(word_len);
			line_chars = ggw_pkg::LENGTH_BITS'((span > SAT) ? SAT : span);
			para_chars = 1'b1;
			in_word = 1'b0;
			emit(ggw_pkg::KIND_WORD, word_start, word_len, ggw_pkg::COLUMN_BITS'(col), ovf);
		endfunction

		function void close_para();
			if (para_blank) begin
				emit(ggw_pkg::KIND_EMPTY, '0, '0, '0, 1'b0);
				line_idx++;
			end else if (para_chars) begin
				line_idx++;
			end
			line_chars = '0;
			para_chars = 1'b0;
			para_blank = 1'b1;
		endfunction

		// expected records of one accepted text byte
		function void note_byte(logic [ggw_pkg::CH_BITS-1:0] ch, logic fin);
			bit blank;
			blank = ch == ggw_pkg::CH_SP ||
				(ch >= ggw_pkg::CH_WS_LO && ch <= ggw_pkg::CH_WS_HI);
			byte_recs.delete();
			if (wrap_on) begin
				if (!blank) begin
					if (!in_word) begin
						in_word = 1'b1;
						word_start = pos;
						word_len = 1;
						word_sat = 1'b0;
					end else if (word_len == SAT) begin
						word_sat = 1'b1;
					end else begin
						word_len++;
					end
					para_blank = 1'b0;
				end else begin
					if (in_word)
						place_word();
					if (ch != ggw_pkg::CH_SP && ch != ggw_pkg::CH_CR && ch != ggw_pkg::CH_LF)
						para_blank = 1'b0;
					if (ch == ggw_pkg::CH_LF)
						close_para();
				end
				if (fin && ch != ggw_pkg::CH_LF) begin
					if (in_word)
						place_word();
					close_para();
				end
			end else if (ch == ggw_pkg::CH_LF) begin
				emit(ggw_pkg::KIND_RAW, raw_start, raw_len, '0, raw_sat);
				line_idx++;
				raw_start = pos + 1'b1;
				raw_len = '0;
				raw_sat = 1'b0;
				if (fin) begin
					emit(ggw_pkg::KIND_RAW, raw_start, '0, '0, 1'b0);
					line_idx++;
				end
			end else begin
				if (ch != ggw_pkg::CH_CR) begin
					if (raw_len == SAT)
						raw_sat = 1'b1;
					else
						raw_len++;
				end
				if (fin && raw_len != 0) begin
					emit(ggw_pkg::KIND_RAW, raw_start, raw_len, '0, raw_sat);
					line_idx++;
				end
			end
			pos++;
			if (fin) begin
				if (byte_recs.size() == 0)
					emit(ggw_pkg::KIND_END, '0, '0, '0, 1'b0);
				byte_recs[byte_recs.size() - 1].last = 1'b1;
				clear_text();
			end
			pending_recs = {pending_recs, byte_recs};
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 50)
				$display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_record(ggw_pkg::rec_t got);
			ggw_pkg::rec_t want;
			rec_no++;
			if (pending_recs.size() == 0) begin
				report_mismatch($sformatf("record %0d arrived with none expected", rec_no));
				return;
			end
			want = pending_recs.pop_front();
			if (got.kind !== want.kind)
				report_mismatch($sformatf("record %0d kind %0d, want %0d",
					rec_no, got.kind, want.kind));
			if (got.start_res !== want.start_res)
				report_mismatch($sformatf("record %0d start %0d, want %0d",
					rec_no, got.start_res, want.start_res));
			if (got.length !== want.length)
				report_mismatch($sformatf("record %0d length %0d, want %0d",
					rec_no, got.length, want.length));
			if (got.line_number !== want.line_number)
				report_mismatch($sformatf("record %0d line %0d, want %0d",
					rec_no, got.line_number, want.line_number));
			if (got.column !== want.column)
				report_mismatch($sformatf("record %0d column %0d, want %0d",
					rec_no, got.column, want.column));
			if (got.overflow !== want.overflow)
				report_mismatch($sformatf("record %0d overflow %0b, want %0b",
					rec_no, got.overflow, want.overflow));
			if (got.last !== want.last)
				report_mismatch($sformatf("record %0d last %0b, want %0b",
					rec_no, got.last, want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [ggw_pkg::LIMIT_BITS-1:0] cfg_data;

	ggw_stream_if #(.payload_t(ggw_pkg::text_t)) text_ch ();
	ggw_stream_if #(.payload_t(ggw_pkg::rec_t)) place_ch ();

	wrap_checker sb = new();

	int burst_left = 0;
	int rx_hold = 0;
	int rx_style = 0;
	int rx_cycles = 0;
	int random_sent = 0;

	greedy_word_wrap_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.text(text_ch),
		.placement(place_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("tb_top failed");
		$finish;
	end

	// receiver stalls: one of four styles, redrawn at random periodically
	always @(negedge clk) begin
		rx_cycles++;
		if (rx_cycles % 64 == 0)
			rx_style = $urandom_range(0, 3);
		if (!arst_n) begin
			place_ch.ready = 1'b0;
		end else if (rx_hold > 0) begin
			place_ch.ready = 1'b0;
			rx_hold--;
		end else begin
			case (rx_style)
				0: place_ch.ready = 1'b1;
				1: place_ch.ready = $urandom_range(0, 1);
				2: begin
					place_ch.ready = 1'b1;
					if ($urandom_range(0, 9) == 0)
						rx_hold = $urandom_range(1, 8);
				end
				default: place_ch.ready = $urandom_range(0, 3) != 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && place_ch.valid && place_ch.ready)
			sb.check_record(place_ch.payload);
	end

	task automatic take_break();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		repeat (gap) begin
			@(negedge clk);
			text_ch.valid = 1'b0;
			@(posedge clk);
		end
		burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 16);
	endtask

	task automatic send_byte(logic [ggw_pkg::CH_BITS-1:0] ch, logic fin);
		if (burst_left == 0)
			take_break();
		burst_left--;
		@(negedge clk);
		text_ch.valid = 1'b1;
		text_ch.payload.ch = ch;
		text_ch.payload.last_char = fin;
		do
			@(posedge clk);
		while (!text_ch.ready);
		sb.note_byte(ch, fin);
	endtask

	task automatic send_str(string s, bit fin);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], fin && i == s.len() - 1);
	endtask

	// wait out every pending record, then the latency of a silent byte
	task automatic drain();
		@(negedge clk);
		text_ch.valid = 1'b0;
		while (sb.pending_recs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [ggw_pkg::LIMIT_BITS-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == ggw_pkg::CFG_WRAP_ENABLE)
			sb.wrap_on = value[0];
		else
			sb.limit = value;
	endtask

	task automatic set_mode(bit wrap, logic [ggw_pkg::LIMIT_BITS-1:0] lim);
		write_reg(ggw_pkg::CFG_WRAP_ENABLE,
			{(ggw_pkg::LIMIT_BITS-1)'($urandom_range(0, 2047)), wrap});
		write_reg(ggw_pkg::CFG_LINE_LIMIT, lim);
	endtask

	task automatic random_text(bit pause_mid);
		logic [ggw_pkg::CH_BITS-1:0] chars[$];
		logic [ggw_pkg::CH_BITS-1:0] c;
		int target;
		int pick;
		int run;
		target = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 40);
		if ($urandom_range(0, 4) == 0) begin
			repeat (target) begin
				if ($urandom_range(0, 1))
					c = ggw_pkg::CH_BITS'($urandom_range(0, 255));
				else
					c = ggw_pkg::CH_BITS'($urandom_range(ggw_pkg::CH_WS_LO, ggw_pkg::CH_WS_HI));
				chars = {chars, c};
			end
		end else begin
			while (chars.size() < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					run = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 14 : 6);
					repeat (run) begin
						do
							c = ggw_pkg::CH_BITS'($urandom_range(0, 255));
						while (c == ggw_pkg::CH_SP ||
							(c >= ggw_pkg::CH_WS_LO && c <= ggw_pkg::CH_WS_HI));
						chars = {chars, c};
					end
				end else if (pick < 80) begin
					repeat ($urandom_range(1, 2)) chars = {chars, ggw_pkg::CH_SP};
				end else if (pick < 90) begin
					chars = {chars, ggw_pkg::CH_LF};
				end else if (pick < 95) begin
					chars = {chars, ggw_pkg::CH_CR};
				end else begin
					c = ggw_pkg::CH_BITS'($urandom_range(ggw_pkg::CH_WS_LO,
						ggw_pkg::CH_WS_HI - 1));
					chars = {chars, c};
				end
			end
			if ($urandom_range(0, 5) == 0)
				chars = {chars, ggw_pkg::CH_LF};
		end
		foreach (chars[i]) begin
			if (pause_mid && i == chars.size() / 2) begin
				drain();
				if ($urandom_range(0, 1))
					write_reg(ggw_pkg::CFG_WRAP_ENABLE, {11'd0, !sb.wrap_on});
			end
			send_byte(chars[i], i == chars.size() - 1);
			random_sent++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ggw_pkg::CFG_WRAP_ENABLE;
		cfg_data = '0;
		text_ch.valid = 1'b0;
		text_ch.payload = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings first
		send_str("\n", 1'b0);
		send_str(" \015\n", 1'b0);
		send_str("\t\013\014\n", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_str(" z ", 1'b1);
		send_str(" ", 1'b1);
		send_str("\t", 1'b1);
		send_str("\n", 1'b1);
		drain();
		set_mode(1'b1, 12'd3);
		send_str("ab cd", 1'b1);
		drain();
		set_mode(1'b1, 12'd0);
		send_str("a b", 1'b1);
		drain();
		set_mode(1'b0, 12'd4095);
		send_str("a\015\n", 1'b1);
		drain();
		set_mode(1'b1, 12'd80);

		random_text(1'b1);
		while (random_sent < 1700) begin
			if ($urandom_range(0, 11) == 0) begin
				drain();
				case ($urandom_range(0, 7))
					0: set_mode($urandom_range(0, 3) != 0, 12'd0);
					1: set_mode($urandom_range(0, 3) != 0, 12'd1);
					2: set_mode($urandom_range(0, 3) != 0, 12'd4095);
					3: set_mode($urandom_range(0, 3) != 0, 12'd80);
					4: set_mode($urandom_range(0, 3) != 0,
						ggw_pkg::LIMIT_BITS'($urandom_range(1, 4095)));
					default: set_mode($urandom_range(0, 3) != 0,
						ggw_pkg::LIMIT_BITS'($urandom_range(2, 20)));
				endcase
			end
			random_text($urandom_range(0, 39) == 0);
		end

		// short text at a tight limit, ending in wrap mode
		drain();
		set_mode(1'b1, 12'd3);
		send_str("ab cd e", 1'b1);

		drain();
		repeat (20) @(posedge clk);
		if (sb.pending_recs.size() != 0)
			sb.report_mismatch($sformatf("%0d records never arrived", sb.pending_recs.size()));
		if (sb.mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
